FILE: rtl/core/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants for the centroid bounding sphere block.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int unsigned MaxVertsDefault = 1024;
  localparam int unsigned CoordW = 16;
  localparam int unsigned RadiusW = 17;
  localparam int unsigned TotalW = 11;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
    logic               last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] center_z;
    logic [16:0]        sphere_radius;
    logic [10:0]        vertex_total;
    logic               overflowed;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // write vertex, add to sums
    logic ovf_set;    // vertex dropped, store full
    logic div_start;  // start the three centroid divisions
    logic div_step;   // one restoring division step
    logic div_done;   // fix signs, latch centroid
    logic scan_rd;    // issue store read at scan address
    logic scan_acc;   // accumulate distance of read data
    logic scan_adv;   // advance scan address
    logic sqrt_start; // start square root
    logic sqrt_step;  // one square root step
    logic clear;      // clear sums and count for next mesh
  } cbs_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic full;       // count equals store depth
    logic empty;      // count is zero
    logic div_last;   // final division step
    logic scan_last;  // scan address at last stored vertex
    logic sqrt_last;  // final square root step
  } cbs_sts_t;

endpackage

FILE: rtl/core/centroid_bounding_sphere_top.sv
// ----------------------------------------------------------------------------
// centroid_bounding_sphere_top
// Centroid and bounding radius of a streamed mesh.
// ----------------------------------------------------------------------------
// Vertices are taken one per cycle while the block is loading, and stored; the
// request marked last starts the result: after a setup state a serial divider
// forms the centroid and a further state applies the signs, one pass over the
// vertex store (one read per cycle, single RAM port) finds the largest squared
// distance, and a bit-pair square root forms the radius before the result is
// offered.
// Input is held off from the last vertex until the result is taken.
// Vertices beyond MaxVerts are dropped and flagged in overflowed.
module centroid_bounding_sphere_top #(
  parameter int unsigned MaxVerts = cbs_pkg::MaxVertsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cbs_pkg::vertex_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cbs_pkg::result_t out_data
);
  import cbs_pkg::*;

  cbs_cmd_t cmd;
  cbs_sts_t sts;

  cbs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .last_vertex (in_data.last_vertex),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  cbs_datapath #(.MaxVerts(MaxVerts)) u_dp (
    .clk (clk),
    .rst (rst),
    .vin (in_data),
    .cmd (cmd),
    .sts (sts),
    .res (out_data)
  );

endmodule

FILE: rtl/core/cbs_ram.sv
// ----------------------------------------------------------------------------
// cbs_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cbs_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write or read one entry per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/cbs_datapath.sv
// ----------------------------------------------------------------------------
// cbs_datapath
// Vertex store, running sums, serial divider, distance scan, serial sqrt.
// ----------------------------------------------------------------------------
module cbs_datapath #(
  parameter int unsigned MaxVerts = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  cbs_pkg::vertex_t vin,
  input  cbs_pkg::cbs_cmd_t cmd,
  output cbs_pkg::cbs_sts_t sts,
  output cbs_pkg::result_t res
);
  import cbs_pkg::*;

  localparam int unsigned AddrW = (MaxVerts > 1) ? $clog2(MaxVerts) : 1;
  localparam int unsigned CntW = $clog2(MaxVerts + 1);
  localparam int unsigned SumW = 16 + CntW;
  localparam int unsigned DivCntW = $clog2(SumW + 1);
  localparam int unsigned SqW = 36;  // max d2 is 3*(2^17)^2 < 2^36
  localparam int unsigned SqSteps = SqW / 2;
  localparam int unsigned SqCntW = $clog2(SqSteps + 1);

  logic signed [SumW-1:0] sum_x, sum_y, sum_z;
  logic [CntW-1:0]        vertex_count;
  logic                   overflow_flag;
  logic [AddrW-1:0]       scan_addr;
  logic [AddrW-1:0]       ram_addr;
  logic [47:0]            ram_rdata;

  // Restoring division state: magnitude quotient/remainder per axis.
  logic [SumW-1:0]    quo [3];
  logic [CntW:0]      rem [3];
  logic [2:0]         neg;
  logic [DivCntW-1:0] div_cnt;
  logic signed [16:0] ctr [3];

  // Distance stage registers.
  logic signed [17:0] dlt [3];
  logic               dlt_vld;
  logic [SqW-1:0]     best;
  logic [SqW-1:0]     sq_part [3];
  logic               sq_vld;

  // Square root state.
  logic [SqW-1:0]    sq_v;
  logic [SqW-1:0]    sq_res;
  logic [SqW-1:0]    sq_bit;
  logic [SqCntW-1:0] sq_cnt;

  assign ram_addr = cmd.load ? vertex_count[AddrW-1:0] : scan_addr;

  cbs_ram #(.Width(48), .Depth(MaxVerts)) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .addr  (ram_addr),
    .wdata ({vin.vertex_x, vin.vertex_y, vin.vertex_z}),
    .rdata (ram_rdata)
  );

  // Status back to the controller.
  assign sts.full      = (vertex_count == CntW'(MaxVerts));
  assign sts.empty     = (vertex_count == '0);
  assign sts.div_last  = (div_cnt == DivCntW'(1));
  assign sts.scan_last = ({1'b0, scan_addr} == CntW'(vertex_count - CntW'(1)));
  assign sts.sqrt_last = (sq_cnt == SqCntW'(1));

  // Hold sums, count and overflow flag across one mesh.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sum_x         <= '0;
      sum_y         <= '0;
      sum_z         <= '0;
      vertex_count  <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (cmd.load) begin
        sum_x        <= sum_x + SumW'(vin.vertex_x);
        sum_y        <= sum_y + SumW'(vin.vertex_y);
        sum_z        <= sum_z + SumW'(vin.vertex_z);
        vertex_count <= vertex_count + CntW'(1);
      end
      if (cmd.ovf_set) begin
        overflow_flag <= 1'b1;
      end
    end
  end

  // Divide |sum| by count one quotient bit per cycle, all axes in parallel.
  logic [SumW-1:0] mag [3];
  logic [CntW:0]   trial [3];
  logic [SumW-1:0] sgn_q [3];
  always_comb begin
    mag[0] = sum_x[SumW-1] ? SumW'(-sum_x) : SumW'(sum_x);
    mag[1] = sum_y[SumW-1] ? SumW'(-sum_y) : SumW'(sum_y);
    mag[2] = sum_z[SumW-1] ? SumW'(-sum_z) : SumW'(sum_z);
    for (int a = 0; a < 3; a++) begin
      trial[a] = {rem[a][CntW-1:0], quo[a][SumW-1]};
      sgn_q[a] = neg[a] ? SumW'(-quo[a]) : quo[a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      for (int a = 0; a < 3; a++) begin
        quo[a] <= mag[a];
        rem[a] <= '0;
      end
      neg     <= {sum_z[SumW-1], sum_y[SumW-1], sum_x[SumW-1]};
      div_cnt <= DivCntW'(SumW);
    end else if (cmd.div_step) begin
      for (int a = 0; a < 3; a++) begin
        if (trial[a] >= {1'b0, vertex_count}) begin
          rem[a] <= trial[a] - {1'b0, vertex_count};
          quo[a] <= {quo[a][SumW-2:0], 1'b1};
        end else begin
          rem[a] <= trial[a];
          quo[a] <= {quo[a][SumW-2:0], 1'b0};
        end
      end
      div_cnt <= div_cnt - DivCntW'(1);
    end
    if (cmd.div_done) begin
      for (int a = 0; a < 3; a++) begin
        ctr[a] <= sgn_q[a][16:0];
      end
    end
  end

  // Scan address walks the stored vertices.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      scan_addr <= '0;
    end else if (cmd.scan_adv) begin
      scan_addr <= scan_addr + AddrW'(1);
    end
  end

  // Scan pipeline: read -> delta -> squares -> sum and max.
  logic signed [15:0] rd_c [3];
  assign rd_c[0] = ram_rdata[47:32];
  assign rd_c[1] = ram_rdata[31:16];
  assign rd_c[2] = ram_rdata[15:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.div_start) begin
      dlt_vld <= 1'b0;
      sq_vld  <= 1'b0;
      best    <= '0;
    end else begin
      dlt_vld <= cmd.scan_acc;
      sq_vld  <= dlt_vld;
      if (sq_vld) begin
        if (sq_part[0] + sq_part[1] + sq_part[2] > best) begin
          best <= sq_part[0] + sq_part[1] + sq_part[2];
        end
      end
    end
    for (int a = 0; a < 3; a++) begin
      dlt[a]     <= 18'(rd_c[a]) - 18'(ctr[a]);
      sq_part[a] <= SqW'(dlt[a] * dlt[a]);
    end
  end

  // Bit-pair square root, one step per cycle.
  logic [SqW-1:0] rb;
  assign rb = sq_res + sq_bit;
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_v   <= best;
      sq_res <= '0;
      sq_bit <= SqW'(1) << (SqW - 2);
      sq_cnt <= SqCntW'(SqSteps);
    end else if (cmd.sqrt_step) begin
      if (sq_v >= rb) begin
        sq_v   <= sq_v - rb;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
      sq_cnt <= sq_cnt - SqCntW'(1);
    end
  end

  assign res.center_x      = ctr[0][15:0];
  assign res.center_y      = ctr[1][15:0];
  assign res.center_z      = ctr[2][15:0];
  assign res.sphere_radius = sq_res[16:0];
  assign res.vertex_total  = TotalW'(vertex_count);
  assign res.overflowed    = overflow_flag;

  // The store is never written beyond its depth.
  assert property (@(posedge clk) disable iff (rst) cmd.load |-> !sts.full)
    else $error("store write while full");
  // Count moves only on a load or a clear.
  assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.load) && !$past(cmd.clear) && !$past(rst) |-> $stable(vertex_count))
    else $error("vertex count changed without a load");
  // Divider and scan never run together.
  assert property (@(posedge clk) disable iff (rst) !(cmd.div_step && cmd.scan_rd))
    else $error("divider and scan overlap");

endmodule

FILE: rtl/core/cbs_ctrl.sv
// ----------------------------------------------------------------------------
// cbs_ctrl
// Sequencer: load vertices, divide, scan the store, square root, deliver.
// ----------------------------------------------------------------------------
module cbs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               last_vertex,
  output logic               out_valid,
  input  logic               out_ready,
  input  cbs_pkg::cbs_sts_t  sts,
  output cbs_pkg::cbs_cmd_t  cmd
);
  import cbs_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD, ST_PREP, ST_DIV, ST_FIX, ST_SCAN, ST_DRAIN, ST_SQRT, ST_OUT
  } state_t;

  state_t     state;
  logic [1:0] drain;
  logic       in_acc;
  // Read data is valid in the cycle after the read.
  logic       cmd_acc_q;

  assign in_ready = (state == ST_LOAD);
  assign in_acc   = in_valid && in_ready;

  // Decode commands from state, the input handshake and the delayed read strobe.
  always_comb begin
    cmd            = '0;
    cmd.load       = in_acc && !sts.full;
    cmd.ovf_set    = in_acc && sts.full;
    cmd.div_start  = (state == ST_PREP);
    cmd.div_step   = (state == ST_DIV);
    cmd.div_done   = (state == ST_FIX);
    cmd.scan_rd    = (state == ST_SCAN);
    cmd.scan_acc   = cmd_acc_q;
    cmd.scan_adv   = (state == ST_SCAN);
    cmd.sqrt_start = (state == ST_DRAIN) && (drain == 2'd0);
    cmd.sqrt_step  = (state == ST_SQRT);
    cmd.clear      = (state == ST_OUT) && out_ready;
  end

  // Hold state, drain count, read strobe and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      drain     <= '0;
      out_valid <= 1'b0;
      cmd_acc_q <= 1'b0;
    end else begin
      cmd_acc_q <= cmd.scan_rd;
      case (state)
        ST_LOAD: begin
          if (in_acc && last_vertex) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (sts.div_last) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          state <= sts.empty ? ST_DRAIN : ST_SCAN;
          drain <= 2'd3;
        end
        ST_SCAN: begin
          if (sts.scan_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain == 2'd0) begin
            state <= ST_SQRT;
          end else begin
            drain <= drain - 2'd1;
          end
        end
        ST_SQRT: begin
          if (sts.sqrt_last) begin
            state     <= ST_OUT;
            out_valid <= 1'b1;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            state     <= ST_LOAD;
            out_valid <= 1'b0;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input open while result pending");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) && sts.sqrt_last |=> out_valid)
    else $error("result not raised after sqrt");

endmodule
